/* sv/pwm_pkg.sv */
// Package for the PWM pulse width monitor: constants, state encoding, compare result type.
`timescale 1ns / 1ps
package pwm_pkg;

    localparam int TIME_W   = 32;               // timestamp and width counters
    localparam int TOL_W    = 7;                // tolerance register
    localparam int COEF_W   = 8;                // 100 +/- tolerance fits in 8 bits
    localparam int PROD_W   = TIME_W + COEF_W;  // scaled products
    localparam int PCT_W    = 7;                // reported percent
    localparam int QUOT_W   = 8;                // quotient bits produced by the divider
    localparam int QBIT_W   = $clog2(QUOT_W);

    localparam logic [TOL_W-1:0]  TOL_RESET  = 7'd10;
    localparam logic [COEF_W-1:0] PCT_SCALE  = 8'd100;
    localparam logic [TIME_W-1:0] MIN_WIDTHS = 32'd3;
    localparam logic [TIME_W-1:0] CNT_MAX    = '1;
    localparam logic [QUOT_W-1:0] PCT_LIMIT  = 8'd100;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_W,
        ST_MUL_HI0,
        ST_MUL_LO0,
        ST_MUL_HI1,
        ST_MUL_LO1,
        ST_CHECK,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic lt;   // x < y
        logic gt;   // x > y
    } t_cmp;

endpackage

/* sv/pwm_alu.sv */
// Shared arithmetic unit: registered 32x8 multiplier and a 40-bit compare/subtract.
`timescale 1ns / 1ps
module pwm_alu
    import pwm_pkg::*;
(
    input  logic              i_clk,
    input  logic [TIME_W-1:0] i_mul_a,
    input  logic [COEF_W-1:0] i_mul_b,
    output logic [PROD_W-1:0] o_prod,
    input  logic [PROD_W-1:0] i_cmp_x,
    input  logic [PROD_W-1:0] i_cmp_y,
    output t_cmp              o_cmp,
    output logic [PROD_W-1:0] o_diff
);

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;
    logic [PROD_W:0]   w_sub;

    always_comb begin
        n_prod = PROD_W'(i_mul_a) * PROD_W'(i_mul_b);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod    = r_prod;
    assign w_sub     = {1'b0, i_cmp_x} - {1'b0, i_cmp_y};
    assign o_diff    = w_sub[PROD_W-1:0];
    assign o_cmp.lt  = w_sub[PROD_W];
    assign o_cmp.gt  = !w_sub[PROD_W] && (w_sub[PROD_W-1:0] != '0);

endmodule

/* sv/pwm_pulse_width_monitor.sv */
// Top level of the PWM pulse width monitor: sequencer, monitor state and output register.
`timescale 1ns / 1ps
// Takes timestamped pin samples and reports, at every rising edge after the first, the high
// time latched at the last falling edge and the period since the previous rising edge. Once
// three widths have been seen, a width outside the tolerance band of both previous widths is
// flagged, counted, and reported as errors*100/widths (truncated, widths counted before this
// one). All time differences wrap modulo 2^32; both counters saturate at 2^32-1.
// A sample that causes no report only updates the monitor state. A reporting edge up to the
// third width goes straight to the output register; later ones run the band check, and a
// flagged width the division as well, since one shared 32x8 multiplier and one 40-bit
// compare/subtract do the six products (five for the band test, one for errors*100), four
// compares and an 8-step restoring division in turn. The input stalls while an item is in
// work; a result sits in the output register so the next sample is taken while it waits.
module pwm_pulse_width_monitor
    import pwm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [TOL_W-1:0]  i_cfg_data,
    // sample channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_pin_level,
    input  logic [TIME_W-1:0] i_time_ms,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [TIME_W-1:0] o_high_width,
    output logic [TIME_W-1:0] o_period_len,
    output logic              o_error_flag,
    output logic [TIME_W-1:0] o_error_count,
    output logic [PCT_W-1:0]  o_error_percent
);

    t_state r_state, n_state;

    // monitor state
    logic              r_last_level, n_last_level;
    logic              r_first, n_first;
    logic [TIME_W-1:0] r_rise_time, n_rise_time;
    logic [TIME_W-1:0] r_latched, n_latched;
    logic [TIME_W-1:0] r_hist0, n_hist0;
    logic [TIME_W-1:0] r_hist1, n_hist1;
    logic [TIME_W-1:0] r_width_total, n_width_total;
    logic [TIME_W-1:0] r_dev_total, n_dev_total;
    logic [TOL_W-1:0]  r_tol, n_tol;

    // per-item work registers
    logic [TIME_W-1:0] r_w, n_w;
    logic [TIME_W-1:0] r_period, n_period;
    logic [PROD_W-1:0] r_scaled, n_scaled;
    logic              r_out0, n_out0;
    logic              r_out1, n_out1;
    logic              r_flag, n_flag;
    logic [PROD_W-1:0] r_rem, n_rem;
    logic [QUOT_W-1:0] r_q, n_q;
    logic [QBIT_W-1:0] r_bit, n_bit;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [TIME_W-1:0] r_o_width, n_o_width;
    logic [TIME_W-1:0] r_o_period, n_o_period;
    logic              r_o_flag, n_o_flag;
    logic [TIME_W-1:0] r_o_count, n_o_count;
    logic [PCT_W-1:0]  r_o_pct, n_o_pct;

    // shared unit hookup
    logic [TIME_W-1:0] w_mul_a;
    logic [COEF_W-1:0] w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_cmp_x;
    logic [PROD_W-1:0] w_cmp_y;
    t_cmp              w_cmp;
    logic [PROD_W-1:0] w_diff;

    logic              w_accept;
    logic              w_out_free;
    logic              w_lo_ok;
    logic [COEF_W-1:0] w_coef_hi;
    logic [COEF_W-1:0] w_coef_lo;
    logic [TIME_W-1:0] w_dev_inc;
    logic [PROD_W-1:0] w_div_sh;
    logic [PCT_W-1:0]  w_pct;

    pwm_alu u_alu (
        .i_clk   (i_clk),
        .i_mul_a (w_mul_a),
        .i_mul_b (w_mul_b),
        .o_prod  (w_prod),
        .i_cmp_x (w_cmp_x),
        .i_cmp_y (w_cmp_y),
        .o_cmp   (w_cmp),
        .o_diff  (w_diff)
    );

    assign o_stall    = (r_state != ST_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // lower band only exists below 100 percent
    assign w_lo_ok   = (r_tol < TOL_W'(PCT_SCALE));
    assign w_coef_hi = PCT_SCALE + {1'b0, r_tol};
    assign w_coef_lo = PCT_SCALE - {1'b0, r_tol};
    assign w_dev_inc = (r_dev_total == CNT_MAX) ? r_dev_total : r_dev_total + 1'b1;
    assign w_div_sh  = PROD_W'(r_width_total) << r_bit;
    assign w_pct     = !r_flag ? '0 :
                       (r_q > PCT_LIMIT) ? PCT_W'(PCT_LIMIT) : r_q[PCT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level  <= 1'b0;
            r_first       <= 1'b1;
            r_rise_time   <= '0;
            r_latched     <= '0;
            r_hist0       <= '0;
            r_hist1       <= '0;
            r_width_total <= '0;
            r_dev_total   <= '0;
            r_tol         <= TOL_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_last_level  <= n_last_level;
            r_first       <= n_first;
            r_rise_time   <= n_rise_time;
            r_latched     <= n_latched;
            r_hist0       <= n_hist0;
            r_hist1       <= n_hist1;
            r_width_total <= n_width_total;
            r_dev_total   <= n_dev_total;
            r_tol         <= n_tol;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w        <= n_w;
        r_period   <= n_period;
        r_scaled   <= n_scaled;
        r_out0     <= n_out0;
        r_out1     <= n_out1;
        r_flag     <= n_flag;
        r_rem      <= n_rem;
        r_q        <= n_q;
        r_bit      <= n_bit;
        r_o_width  <= n_o_width;
        r_o_period <= n_o_period;
        r_o_flag   <= n_o_flag;
        r_o_count  <= n_o_count;
        r_o_pct    <= n_o_pct;
    end

    always_comb begin
        n_state       = r_state;
        n_last_level  = r_last_level;
        n_first       = r_first;
        n_rise_time   = r_rise_time;
        n_latched     = r_latched;
        n_hist0       = r_hist0;
        n_hist1       = r_hist1;
        n_width_total = r_width_total;
        n_dev_total   = r_dev_total;
        n_tol         = i_cfg_we ? i_cfg_data : r_tol;
        n_w           = r_w;
        n_period      = r_period;
        n_scaled      = r_scaled;
        n_out0        = r_out0;
        n_out1        = r_out1;
        n_flag        = r_flag;
        n_rem         = r_rem;
        n_q           = r_q;
        n_bit         = r_bit;
        n_out_valid   = r_out_valid && i_stall;
        n_o_width     = r_o_width;
        n_o_period    = r_o_period;
        n_o_flag      = r_o_flag;
        n_o_count     = r_o_count;
        n_o_pct       = r_o_pct;

        w_mul_a = r_w;
        w_mul_b = PCT_SCALE;
        w_cmp_x = r_scaled;
        w_cmp_y = w_prod;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_last_level = i_pin_level;
                    if (r_last_level && !i_pin_level) begin
                        n_latched = i_time_ms - r_rise_time;
                    end else if (!r_last_level && i_pin_level) begin
                        n_rise_time = i_time_ms;
                        n_first     = 1'b0;
                        if (!r_first) begin
                            // width repeats if no falling edge came in between
                            n_w      = r_latched;
                            n_period = i_time_ms - r_rise_time;
                            n_flag   = 1'b0;
                            n_q      = '0;
                            n_state  = (r_width_total >= MIN_WIDTHS) ? ST_MUL_W : ST_DONE;
                        end
                    end
                end
            end
            ST_MUL_W: begin
                w_mul_a = r_w;
                w_mul_b = PCT_SCALE;
                n_state = ST_MUL_HI0;
            end
            ST_MUL_HI0: begin
                w_mul_a  = r_hist0;
                w_mul_b  = w_coef_hi;
                n_scaled = w_prod;
                n_state  = ST_MUL_LO0;
            end
            ST_MUL_LO0: begin
                w_mul_a = r_hist0;
                w_mul_b = w_coef_lo;
                n_out0  = w_cmp.gt;
                n_state = ST_MUL_HI1;
            end
            ST_MUL_HI1: begin
                w_mul_a = r_hist1;
                w_mul_b = w_coef_hi;
                n_out0  = r_out0 || (w_lo_ok && w_cmp.lt);
                n_state = ST_MUL_LO1;
            end
            ST_MUL_LO1: begin
                w_mul_a = r_hist1;
                w_mul_b = w_coef_lo;
                n_out1  = w_cmp.gt;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                // start errors*100 in case this width is flagged
                w_mul_a = w_dev_inc;
                w_mul_b = PCT_SCALE;
                if (r_out0 && (r_out1 || (w_lo_ok && w_cmp.lt))) begin
                    n_flag      = 1'b1;
                    n_dev_total = w_dev_inc;
                    n_state     = ST_DIV_LOAD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV_LOAD: begin
                n_rem   = w_prod;
                n_bit   = QBIT_W'(QUOT_W - 1);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle, msb first
                w_cmp_x = r_rem;
                w_cmp_y = w_div_sh;
                if (!w_cmp.lt) begin
                    n_rem        = w_diff;
                    n_q[r_bit]   = 1'b1;
                end
                if (r_bit == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_o_width     = r_w;
                    n_o_period    = r_period;
                    n_o_flag      = r_flag;
                    n_o_count     = r_dev_total;
                    n_o_pct       = w_pct;
                    n_hist1       = r_hist0;
                    n_hist0       = r_w;
                    n_width_total = (r_width_total == CNT_MAX) ?
                                    r_width_total : r_width_total + 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_high_width    = r_o_width;
    assign o_period_len    = r_o_period;
    assign o_error_flag    = r_o_flag;
    assign o_error_count   = r_o_count;
    assign o_error_percent = r_o_pct;

endmodule

/* dv/pwm_pulse_width_monitor_tb.sv */
// Self-checking testbench for the PWM pulse width monitor, with a built-in predictor.
`timescale 1ns / 1ps
// Drives timestamped pin samples through the valid/stall sample channel and checks every
// report against a cycle-free predictor of the monitor. A directed part covers time wrap,
// zero and full-range widths and periods, the first rising edge, and the tolerance band at
// 0, 100 and 127 percent. A random part then sends PWM trains with jittered, boundary and
// outlier widths, plus ignored samples and broken sequences, under several tolerances.
// The sender works in bursts with gaps, and the receiver stalls on its own pattern.
module pwm_pulse_width_monitor_tb;
    import pwm_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;       // covers the longest item, a flagged width with its division, plus slack
    localparam int ITEM_TARGET  = 1700;
    localparam int PHASES       = 6;
    localparam longint unsigned HUNDRED = 100;

    typedef struct {
        logic [TIME_W-1:0] high_width;
        logic [TIME_W-1:0] period_len;
        logic              error_flag;
        logic [TIME_W-1:0] error_count;
        logic [PCT_W-1:0]  error_percent;
    } t_pwm_report;

    // DUT ports; the inputs are driven from time zero
    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_cfg_we        = 1'b0;
    logic [TOL_W-1:0]  i_cfg_data      = '0;
    logic              i_valid         = 1'b0;
    logic              o_stall;
    logic              i_pin_level     = 1'b0;
    logic [TIME_W-1:0] i_time_ms       = '0;
    logic              o_valid;
    logic              i_stall         = 1'b0;
    logic [TIME_W-1:0] o_high_width;
    logic [TIME_W-1:0] o_period_len;
    logic              o_error_flag;
    logic [TIME_W-1:0] o_error_count;
    logic [PCT_W-1:0]  o_error_percent;

    // predicted monitor state
    logic [TOL_W-1:0]  mon_tol           = TOL_RESET;
    logic              mon_last_level    = 1'b0;
    logic              mon_first_pending = 1'b1;
    logic [TIME_W-1:0] mon_rise_time     = '0;
    logic [TIME_W-1:0] mon_latched       = '0;
    logic [TIME_W-1:0] mon_hist [2]      = '{default: '0};  // [0] is the newest width
    logic [TIME_W-1:0] mon_width_total   = '0;
    logic [TIME_W-1:0] mon_dev_total     = '0;

    t_pwm_report       expected_reports [$];
    int                fail_count  = 0;
    int                cycle_count = 0;
    int                edge_items  = 0;  // transfers that carry a pin edge
    int                burst_left  = 0;
    int                stall_run   = 0;
    logic              stall_lvl   = 1'b0;
    logic [TIME_W-1:0] sim_ms      = '0; // running time of the stimulus

    pwm_pulse_width_monitor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pin_level     (i_pin_level),
        .i_time_ms       (i_time_ms),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_high_width    (o_high_width),
        .o_period_len    (o_period_len),
        .o_error_flag    (o_error_flag),
        .o_error_count   (o_error_count),
        .o_error_percent (o_error_percent)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver back-pressure: runs of stall and runs of no stall, random lengths.
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_lvl = ($urandom_range(0, 9) < 4);
            stall_run = stall_lvl ? $urandom_range(1, 20) : $urandom_range(1, 60);
        end
        stall_run = stall_run - 1;
        i_stall <= stall_lvl;
    end

    // Exact integer form of the band test: w*100 outside p*(100 -/+ tol).
    function automatic logic outside_band(input logic [TIME_W-1:0] w,
                                          input logic [TIME_W-1:0] p,
                                          input logic [TOL_W-1:0] tol);
        longint unsigned scaled;
        longint unsigned upper;
        longint unsigned lower;
        scaled = longint'(w) * HUNDRED;
        upper  = longint'(p) * (HUNDRED + tol);
        if (scaled > upper)
            return 1'b1;
        if (tol < HUNDRED) begin
            lower = longint'(p) * (HUNDRED - tol);
            if (scaled < lower)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the predicted monitor by one sample; queue a report on each rising edge but the first.
    task automatic predict_sample(input logic lvl, input logic [TIME_W-1:0] t);
        t_pwm_report     rep;
        longint unsigned quot;
        if (mon_last_level && !lvl) begin
            mon_latched = t - mon_rise_time;
        end else if (!mon_last_level && lvl) begin
            rep.period_len = t - mon_rise_time;
            mon_rise_time  = t;
            if (!mon_first_pending) begin
                rep.high_width    = mon_latched;
                rep.error_flag    = 1'b0;
                rep.error_percent = '0;
                if (mon_width_total >= MIN_WIDTHS &&
                    outside_band(mon_latched, mon_hist[0], mon_tol) &&
                    outside_band(mon_latched, mon_hist[1], mon_tol)) begin
                    rep.error_flag = 1'b1;
                    if (mon_dev_total != CNT_MAX)
                        mon_dev_total = mon_dev_total + 1;
                    // divisor is the width count before this width
                    quot = (longint'(mon_dev_total) * HUNDRED) / longint'(mon_width_total);
                    rep.error_percent = (quot > HUNDRED) ? PCT_W'(HUNDRED) : PCT_W'(quot);
                end
                rep.error_count = mon_dev_total;
                mon_hist[1] = mon_hist[0];
                mon_hist[0] = mon_latched;
                if (mon_width_total != CNT_MAX)
                    mon_width_total = mon_width_total + 1;
                expected_reports.push_back(rep);
            end
            mon_first_pending = 1'b0;
        end
        mon_last_level = lvl;
    endtask

    // One sample transfer. Called at a falling edge, returns at a falling edge.
    task automatic send_sample(input logic lvl, input logic [TIME_W-1:0] t);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left  = burst_left - 1;
        i_valid     <= 1'b1;
        i_pin_level <= lvl;
        i_time_ms   <= t;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (lvl != mon_last_level)
            edge_items = edge_items + 1;
        predict_sample(lvl, t);
        @(negedge i_clk);
    endtask

    // With the pin high: fall after w ms, rise again p ms after the last rise.
    task automatic drive_period(input logic [TIME_W-1:0] w, input logic [TIME_W-1:0] p);
        send_sample(1'b0, sim_ms + w);
        send_sample(1'b1, sim_ms + p);
        sim_ms = sim_ms + p;
    endtask

    // Let every report arrive, then give a non-reporting sample time to finish.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] tol);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= tol;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mon_tol = tol;
    endtask

    // Output side: every accepted report against the oldest expectation.
    function automatic void check_field(input string name, input logic [TIME_W-1:0] exp_val,
                                        input logic [TIME_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
            fail_count = fail_count + 1;
        end
    endfunction

    always @(posedge i_clk) begin : check_reports
        t_pwm_report exp_rep;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_reports.size() == 0) begin
                $error("report with nothing expected: width %0h period %0h",
                       o_high_width, o_period_len);
                fail_count = fail_count + 1;
            end else begin
                exp_rep = expected_reports.pop_front();
                check_field("high_width", exp_rep.high_width, o_high_width);
                check_field("period_len", exp_rep.period_len, o_period_len);
                check_field("error_flag", TIME_W'(exp_rep.error_flag),
                            TIME_W'(o_error_flag));
                check_field("error_count", exp_rep.error_count, o_error_count);
                check_field("error_percent", TIME_W'(exp_rep.error_percent),
                            TIME_W'(o_error_percent));
            end
        end
    end

    // First rising edge, time wrap, zero and full-range widths and periods.
    task automatic test_first_edge_and_wrap();
        write_tolerance(TOL_RESET);
        send_sample(1'b0, '0);                  // level unchanged: ignored
        sim_ms = 32'hFFFF_FFF0;
        send_sample(1'b1, sim_ms);              // first rise: no report
        drive_period(32'h20, 32'h40);           // fall and rise past the wrap
        drive_period('0, '0);                   // zero width, zero period
        drive_period(32'd1, 32'hFFFF_FFF0);     // time runs backwards
        drive_period(32'd50, 32'd60);           // third width known: flagged
        drive_period('1, '1);                   // full-range products
        drive_period('1, '1);
    endtask

    // Band edges at the tolerance extremes.
    task automatic test_band_limits();
        write_tolerance('0);
        drive_period(32'd1000, 32'd2000);
        drive_period(32'd1000, 32'd2000);       // equal widths pass at zero tolerance
        drive_period(32'd1001, 32'd2000);       // one over
        drive_period(32'd999, 32'd2000);        // one under
        write_tolerance(7'd100);
        drive_period('0, 32'd500);              // lower bound disabled
        drive_period(32'd2003, 32'd4000);
        drive_period(32'd4006, 32'd8000);       // exactly on the upper bound
        write_tolerance('1);
        drive_period(32'd9000, 32'd9500);
        drive_period(32'd30000, 32'd31000);
    endtask

    // Random PWM trains, with ignored samples and broken sequences mixed in.
    task automatic pwm_trains(input int target);
        logic [TIME_W-1:0] nom;
        logic [TIME_W-1:0] low;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] w;
        logic [TIME_W-1:0] t;
        int                periods;
        int                mode;
        while (edge_items < target) begin
            if ($urandom_range(0, 7) == 0) begin
                nom = $urandom;
                low = $urandom;
            end else begin
                nom = $urandom_range(1, 2000);
                low = $urandom_range(0, 2000);
            end
            case ($urandom_range(0, 5))
                0: sim_ms = $urandom;
                1: sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                default: ;
            endcase
            if (!mon_last_level)
                send_sample(1'b1, sim_ms);
            periods = $urandom_range(4, 30);
            repeat (periods) begin
                span = TIME_W'((longint'(nom) * mon_tol) / HUNDRED);
                mode = $urandom_range(0, 9);
                if (mode < 5) begin
                    w = $urandom_range(0, 1) ? nom + $urandom_range(0, span)
                                             : nom - $urandom_range(0, span);
                end else if (mode < 7) begin
                    // right at the band edge of the nominal width
                    w = ($urandom_range(0, 1) ? nom + span : nom - span)
                        + $urandom_range(0, 2) - 1;
                end else if (mode < 9) begin
                    w = (nom < 32'h4000_0000) ? $urandom_range(0, nom * 3 + 10) : $urandom;
                end else begin
                    w = $urandom;
                end
                drive_period(w, w + low);
                if ($urandom_range(0, 11) == 0) begin
                    if ($urandom_range(0, 1)) begin
                        // repeated level, which the monitor ignores
                        send_sample(mon_last_level, sim_ms + $urandom_range(0, 5));
                    end else begin
                        t = $urandom;
                        send_sample(1'($urandom_range(0, 1)), t);
                        sim_ms = t;
                        if (!mon_last_level)
                            send_sample(1'b1, sim_ms);
                    end
                end
            end
        end
    endtask

    task automatic test_pwm_trains();
        logic [TOL_W-1:0] tols [PHASES];
        int               target;
        tols = '{7'd0, 7'd100, 7'd127, TOL_W'($urandom_range(1, 99)),
                 TOL_W'($urandom_range(101, 126)), TOL_RESET};
        target = edge_items;
        foreach (tols[i]) begin
            write_tolerance(tols[i]);
            target = target + ITEM_TARGET / PHASES;
            pwm_trains(target);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_first_edge_and_wrap();
        test_band_limits();
        test_pwm_trains();
        wait_idle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
sv/pwm_pkg.sv
sv/pwm_alu.sv
sv/pwm_pulse_width_monitor.sv
dv/pwm_pulse_width_monitor_tb.sv
